// ===== hw/rtl/tt_pkg.sv =====
// Shared types and constants for the triangle tangent block.
`timescale 1ns / 1ps
package tt_pkg;

   localparam int NORM_BITS = 24;   // the largest normalised magnitude lies in [2^23, 2^24)
   localparam int SQ_BITS   = 64;   // sum of squares shifted by 14 fits below 2^64
   localparam int ROOT_BITS = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      SLOT_FIRST,
      SLOT_SECOND,
      SLOT_THIRD
   } slot_type;

endpackage

// ===== hw/rtl/tt_front.sv =====
// Front end: holds the first two vertices and forms edges and UV deltas.
`timescale 1ns / 1ps
module tt_front #(
   parameter int POS_WIDTH = 24,
   parameter int UV_WIDTH  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [POS_WIDTH-1:0] pos_x,
   input  logic signed [POS_WIDTH-1:0] pos_y,
   input  logic signed [POS_WIDTH-1:0] pos_z,
   input  logic signed [UV_WIDTH-1:0]  tex_u,
   input  logic signed [UV_WIDTH-1:0]  tex_v,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [3*(POS_WIDTH+1)*2+4*(UV_WIDTH+1)-1:0] out_data
);
   import tt_pkg::*;

   localparam int EW = POS_WIDTH + 1;
   localparam int DW = UV_WIDTH + 1;

   slot_type slot_ff, slot_in;
   logic signed [POS_WIDTH-1:0] p0_ff [3];
   logic signed [POS_WIDTH-1:0] p1_ff [3];
   logic signed [UV_WIDTH-1:0]  t0_ff [2];
   logic signed [UV_WIDTH-1:0]  t1_ff [2];

   logic signed [EW-1:0] e1 [3];
   logic signed [EW-1:0] e2 [3];
   logic signed [DW-1:0] du1, dv1, du2, dv2;
   logic signed [POS_WIDTH-1:0] p [3];
   logic accept;

   assign p[0] = pos_x;
   assign p[1] = pos_y;
   assign p[2] = pos_z;
   assign in_ready = (slot_ff != SLOT_THIRD) || out_ready;
   assign out_valid = in_valid && (slot_ff == SLOT_THIRD);
   assign accept = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = EW'(p1_ff[i]) - EW'(p0_ff[i]);
         e2[i] = EW'(p[i]) - EW'(p0_ff[i]);
      end
      du1 = DW'(t1_ff[0]) - DW'(t0_ff[0]);
      dv1 = DW'(t1_ff[1]) - DW'(t0_ff[1]);
      du2 = DW'(tex_u) - DW'(t0_ff[0]);
      dv2 = DW'(tex_v) - DW'(t0_ff[1]);
      out_data = {dv2, du2, dv1, du1, e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};
   end

   always_comb begin
      unique case (slot_ff)
         SLOT_FIRST:  slot_in = SLOT_SECOND;
         SLOT_SECOND: slot_in = SLOT_THIRD;
         default:     slot_in = SLOT_FIRST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_FIRST;
      end else if (accept) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && slot_ff == SLOT_FIRST) begin
         for (int i = 0; i < 3; i++) p0_ff[i] <= p[i];
         t0_ff[0] <= tex_u;
         t0_ff[1] <= tex_v;
      end
      if (accept && slot_ff == SLOT_SECOND) begin
         for (int i = 0; i < 3; i++) p1_ff[i] <= p[i];
         t1_ff[0] <= tex_u;
         t1_ff[1] <= tex_v;
      end
   end
endmodule

// ===== hw/rtl/tt_queue.sv =====
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
module tt_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end
endmodule

// ===== hw/rtl/tt_back.sv =====
// Back end: cross products, normalisation, square root and divides.
`timescale 1ns / 1ps
module tt_back #(
   parameter int POS_WIDTH = 24,
   parameter int UV_WIDTH  = 16,
   parameter int OUT_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [3*(POS_WIDTH+1)*2+4*(UV_WIDTH+1)-1:0] in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [OUT_WIDTH-1:0] tangent_x,
   output logic signed [OUT_WIDTH-1:0] tangent_y,
   output logic signed [OUT_WIDTH-1:0] tangent_z,
   output logic                        degenerate
);
   import tt_pkg::*;

   localparam int EW   = POS_WIDTH + 1;
   localparam int DW   = UV_WIDTH + 1;
   localparam int PW   = EW + DW;           // one product
   localparam int CW   = PW + 1;            // difference of products
   localparam int MW   = CW;                // magnitude width
   localparam int FRAC = OUT_WIDTH - 2;
   localparam int NUMW = NORM_BITS + FRAC + 8;  // room for the rounding term
   localparam int QW   = NUMW;
   localparam int SQRT_STEPS = ROOT_BITS;
   localparam int SCW  = $clog2(SQRT_STEPS + 2);
   localparam int DCW  = $clog2(NUMW + 2);

   back_state_type state_ff, state_in;

   logic signed [EW-1:0] e1 [3];
   logic signed [EW-1:0] e2 [3];
   logic signed [DW-1:0] du1, dv1, du2, dv2;

   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   logic signed [2*DW-1:0] da_ff, db_ff;

   logic [MW-1:0] mag_ff [3];
   logic [MW-1:0] mag_in [3];
   logic [2:0] neg_ff, neg_in;
   logic degen_ff, degen_in;

   logic [SQ_BITS-1:0] rad_ff;
   logic [SQ_BITS-1:0] rem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [SCW-1:0] sstep_ff;

   logic [1:0] comp_ff;
   logic [DCW-1:0] dstep_ff;
   logic [NUMW-1:0] num_ff;
   logic [ROOT_BITS:0] drem_ff;
   logic [QW-1:0] quo_ff;
   logic signed [OUT_WIDTH-1:0] res_ff [3];

   logic [MW-1:0] mmax;
   logic signed [CW-1:0] cv [3];
   logic signed [2*DW:0] det;
   logic [NORM_BITS-1:0] nm [3];
   logic [2*NORM_BITS-1:0] sq [3];
   logic [SQ_BITS-1:0] trial;
   logic [ROOT_BITS:0] dtry;
   logic [QW-1:0] qsat;
   logic [OUT_WIDTH-1:0] qmag;

   function automatic logic mag_max_ok();
      logic [MW-1:0] m;
      m = mag_ff[0];
      if (mag_ff[1] > m) m = mag_ff[1];
      if (mag_ff[2] > m) m = mag_ff[2];
      return (m < MW'(1 << NORM_BITS)) && (m >= MW'(1 << (NORM_BITS - 1)));
   endfunction

   always_comb begin
      {dv2, du2, dv1, du1, e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]} = in_data;
   end

   assign in_ready  = state_ff == ST_IDLE;
   assign out_valid = state_ff == ST_DONE;
   assign tangent_x = res_ff[0];
   assign tangent_y = res_ff[1];
   assign tangent_z = res_ff[2];
   assign degenerate = degen_ff;

   always_comb begin
      det = (2*DW+1)'(da_ff) - (2*DW+1)'(db_ff);
      mmax = '0;
      for (int i = 0; i < 3; i++) begin
         cv[i] = CW'(pa_ff[i]) - CW'(pb_ff[i]);
         if (det < 0) cv[i] = -cv[i];
         neg_in[i] = cv[i] < 0;
         mag_in[i] = neg_in[i] ? MW'(-cv[i]) : MW'(cv[i]);
         if (mag_in[i] > mmax) mmax = mag_in[i];
      end
      degen_in = (det == 0) || (mmax == '0);
      for (int i = 0; i < 3; i++) begin
         nm[i] = NORM_BITS'(mag_ff[i]);
         sq[i] = nm[i] * nm[i];
      end
      trial = SQ_BITS'({root_ff, 2'b01}) ;
      dtry  = {drem_ff[ROOT_BITS-1:0], num_ff[NUMW-1]};
      qsat  = (quo_ff > QW'(1 << FRAC)) ? QW'(1 << FRAC) : quo_ff;
      qmag  = OUT_WIDTH'(qsat);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_NORM;
         ST_NORM: begin
            if (degen_ff) state_in = ST_DONE;
            else if (mag_max_ok()) state_in = ST_SQRT;
         end
         ST_SQRT: if (sstep_ff == SCW'(SQRT_STEPS + 1)) state_in = ST_DIV;
         ST_DIV:  if (comp_ff == 2'd2 && dstep_ff == DCW'(NUMW + 1)) state_in = ST_DONE;
         ST_DONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               pa_ff[i] <= dv2 * e1[i];
               pb_ff[i] <= dv1 * e2[i];
            end
            da_ff <= du1 * dv2;
            db_ff <= du2 * dv1;
         end
         ST_MUL: begin
            mag_ff   <= mag_in;
            neg_ff   <= neg_in;
            degen_ff <= degen_in;
         end
         ST_NORM: begin
            if (!degen_ff && !mag_max_ok()) begin
               for (int i = 0; i < 3; i++) begin
                  if ((mag_ff[0] | mag_ff[1] | mag_ff[2]) >= MW'(1 << NORM_BITS))
                     mag_ff[i] <= mag_ff[i] >> 1;
                  else
                     mag_ff[i] <= mag_ff[i] << 1;
               end
            end
            rad_ff   <= '0;
            rem_ff   <= '0;
            root_ff  <= '0;
            sstep_ff <= '0;
            comp_ff  <= '0;
            dstep_ff <= '0;
            if (degen_ff) begin
               for (int i = 0; i < 3; i++) res_ff[i] <= '0;
            end
         end
         ST_SQRT: begin
            if (sstep_ff == '0 && root_ff == '0 && rem_ff == '0 && rad_ff == '0) begin
               rad_ff   <= SQ_BITS'(((sq[0] + sq[1]) + SQ_BITS'(sq[2])) << 14);
               sstep_ff <= SCW'(1);
            end else if (sstep_ff != SCW'(SQRT_STEPS + 1)) begin
               if ({rem_ff[SQ_BITS-3:0], rad_ff[SQ_BITS-1:SQ_BITS-2]} >= trial) begin
                  rem_ff  <= {rem_ff[SQ_BITS-3:0], rad_ff[SQ_BITS-1:SQ_BITS-2]} - trial;
                  root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
               end else begin
                  rem_ff  <= {rem_ff[SQ_BITS-3:0], rad_ff[SQ_BITS-1:SQ_BITS-2]};
                  root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
               end
               rad_ff   <= {rad_ff[SQ_BITS-3:0], 2'b00};
               sstep_ff <= sstep_ff + SCW'(1);
            end
         end
         ST_DIV: begin
            if (dstep_ff == '0) begin
               num_ff  <= (NUMW'(mag_ff[comp_ff]) << (FRAC + 7)) + NUMW'(root_ff >> 1);
               drem_ff <= '0;
               quo_ff  <= '0;
               dstep_ff <= DCW'(1);
            end else if (dstep_ff != DCW'(NUMW + 1)) begin
               if (dtry >= {1'b0, root_ff}) begin
                  drem_ff <= dtry - {1'b0, root_ff};
                  quo_ff  <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  drem_ff <= dtry;
                  quo_ff  <= {quo_ff[QW-2:0], 1'b0};
               end
               num_ff   <= {num_ff[NUMW-2:0], 1'b0};
               dstep_ff <= dstep_ff + DCW'(1);
            end else begin
               res_ff[comp_ff] <= neg_ff[comp_ff] ? -qmag : qmag;
               if (comp_ff != 2'd2) begin
                  comp_ff  <= comp_ff + 2'd1;
                  dstep_ff <= '0;
               end
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end
endmodule

// ===== hw/rtl/triangle_tangent.sv =====
// Top level: per-triangle tangent from a vertex stream with texture coordinates.
// From the third vertex: normalising shifts, then a square root and one divide per component;
// the root and divides dominate. A degenerate triangle skips the root and the divides.
// Throughput: vertices enter one per cycle, the third while the two-deep queue has room;
// the back end takes a triangle once its last result is taken; one result per three vertices.
// Reset: synchronous, active high; clears vertex slot, queue and back-end state.
`timescale 1ns / 1ps
module triangle_tangent #(
   parameter int POS_WIDTH = 24,
   parameter int UV_WIDTH  = 16,
   parameter int OUT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up
   input  logic [((3*POS_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tangent_x, tangent_y, tangent_z, degenerate from bit 0 up
   output logic [((3*OUT_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   localparam int FW = 3*(POS_WIDTH+1)*2 + 4*(UV_WIDTH+1);
   localparam int RW = ((3*OUT_WIDTH+1+7)/8)*8;

   logic f_valid, f_ready, b_valid, b_ready;
   logic [FW-1:0] f_data, b_data;
   logic signed [OUT_WIDTH-1:0] tx, ty, tz;
   logic degen;

   tt_front #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .pos_x(req_tdata[POS_WIDTH-1:0]),
      .pos_y(req_tdata[2*POS_WIDTH-1:POS_WIDTH]),
      .pos_z(req_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
      .tex_u(req_tdata[3*POS_WIDTH+UV_WIDTH-1:3*POS_WIDTH]),
      .tex_v(req_tdata[3*POS_WIDTH+2*UV_WIDTH-1:3*POS_WIDTH+UV_WIDTH]),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   tt_queue #(.WIDTH(FW)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   tt_back #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .tangent_x(tx), .tangent_y(ty), .tangent_z(tz), .degenerate(degen)
   );

   assign rsp_tdata = RW'({degen, tz, ty, tx});
endmodule

// ===== verif/tt_checker.sv =====
// Checker for the triangle tangent block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module tt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [103:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] tx;
      logic [15:0] ty;
      logic [15:0] tz;
      logic        degen;
   } tangent_type;

   tangent_type tangent_q[$];
   logic signed [63:0] held_pos[6];
   logic signed [63:0] held_uv[4];
   int unsigned slot;

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic take_vertex(input logic [103:0] d);
      logic signed [63:0] p[3], e1[3], e2[3], c[3];
      logic signed [63:0] u, v, du1, dv1, du2, dv2, det;
      logic [63:0] mag[3], m, s, r, q;
      logic neg[3];
      logic [15:0] o[3];
      tangent_type t;
      for (int i = 0; i < 3; i++) p[i] = $signed(d[i*24 +: 24]);
      u = $signed(d[72 +: 16]);
      v = $signed(d[88 +: 16]);
      if (slot < 2) begin
         for (int i = 0; i < 3; i++) held_pos[slot*3+i] = p[i];
         held_uv[slot*2] = u;
         held_uv[slot*2+1] = v;
         slot++;
         return;
      end
      slot = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = held_pos[3+i] - held_pos[i];
         e2[i] = p[i] - held_pos[i];
      end
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = u - held_uv[0];
      dv2 = v - held_uv[1];
      det = du1 * dv2 - du2 * dv1;
      m = '0;
      for (int i = 0; i < 3; i++) begin
         c[i] = dv2 * e1[i] - dv1 * e2[i];
         if (det < 0) c[i] = -c[i];
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? -c[i] : c[i];
         if (mag[i] > m) m = mag[i];
      end
      if (det == 0 || m == 0) begin
         t = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
         while (m >= (64'd1 << 24)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         while (m < (64'd1 << 23)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
         r = isqrt(s << 14);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 21) + (r >> 1)) / r;
            if (q > 64'd16384) q = 64'd16384;
            o[i] = neg[i] ? -q[15:0] : q[15:0];
         end
         t = '{o[0], o[1], o[2], 1'b0};
      end
      tangent_q = {tangent_q, t};
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot = 0;
      end else begin
         if (req_tvalid && req_tready) take_vertex(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (tangent_q.size() == 0) begin
               $error("unexpected tangent result %h", rsp_tdata);
               fail_count++;
            end else begin
               tangent_type w;
               w = tangent_q.pop_front();
               check_field("tangent_x", w.tx, rsp_tdata[15:0]);
               check_field("tangent_y", w.ty, rsp_tdata[31:16]);
               check_field("tangent_z", w.tz, rsp_tdata[47:32]);
               check_field("degenerate", {15'd0, w.degen}, {15'd0, rsp_tdata[48]});
            end
         end
      end
      pending_count = tangent_q.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      slot = 0;
   end

endmodule

// ===== verif/tb_triangle_tangent.sv =====
// Testbench top for the triangle tangent block: vertex stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_triangle_tangent;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;
   int           fail_count, pending_count;
   int           idle_cycles;
   logic [103:0] vertex_q[$];

   always #5 clock = ~clock;

   triangle_tangent dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   tt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic logic [103:0] pack_vertex(input logic [23:0] x, input logic [23:0] y,
                                                input logic [23:0] z, input logic [15:0] u,
                                                input logic [15:0] v);
      return {v, u, z, y, x};
   endfunction

   task automatic add_vertex(input logic [103:0] d);
      vertex_q = {vertex_q, d};
   endtask

   function automatic logic [23:0] rand_pos(input int mode);
      unique case (mode)
         0: return 24'($urandom());
         1: return 24'h800000;
         2: return 24'h7fffff;
         default: return 24'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic logic [15:0] rand_uv(input int mode);
      unique case (mode)
         0: return 16'($urandom());
         1: return 16'h8000;
         2: return 16'h7fff;
         default: return 16'($signed($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   // watchdog: cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // result side stalls
   initial begin
      int w;
      forever begin
         w = $urandom_range(0, 19);
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      logic [103:0] a;
      int md;
      idle_cycles = 0;
      // degenerate: all equal
      a = pack_vertex(24'd100, 24'd200, 24'd300, 16'd10, 16'd20);
      repeat (3) add_vertex(a);
      // zero tangent with non-zero det: same positions, varied uv
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd0));
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd4096, 16'd0));
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd4096));
      // unit right triangle
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd0));
      add_vertex(pack_vertex(24'h010000, 24'd0, 24'd0, 16'h1000, 16'd0));
      add_vertex(pack_vertex(24'd0, 24'h010000, 24'd0, 16'd0, 16'h1000));
      // extremes, negative det then positive det
      add_vertex(pack_vertex(24'h800000, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff));
      add_vertex(pack_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 16'h7fff, 16'h8000));
      add_vertex(pack_vertex(24'h7fffff, 24'h7fffff, 24'h800000, 16'h8000, 16'h8000));
      add_vertex(pack_vertex(24'hffffff, 24'hffffff, 24'hffffff, 16'hffff, 16'hffff));
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'h7fff, 16'h8000));
      add_vertex(pack_vertex(24'h000001, 24'd0, 24'h000001, 16'h8000, 16'h7fff));
      // tiny tangent magnitude
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd0));
      add_vertex(pack_vertex(24'd1, 24'd0, 24'd0, 16'd1, 16'd0));
      add_vertex(pack_vertex(24'd0, 24'd0, 24'd1, 16'd0, 16'd1));
      for (int i = 0; i < 550; i++) begin
         md = $urandom_range(0, 9);
         if (md > 3) md = 3;
         if ($urandom_range(0, 19) == 0) begin
            // uv repeated within a triangle makes det zero
            add_vertex(pack_vertex(rand_pos(md), rand_pos(md), rand_pos(md), 16'h0123,
                                   16'h0456));
         end else begin
            add_vertex(pack_vertex(rand_pos(md), rand_pos(md), rand_pos(md),
                                   rand_uv(md), rand_uv(md)));
         end
      end
      while (vertex_q.size() % 3 != 0) add_vertex(pack_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd0));

      repeat (9) @(posedge clock);
      reset <= 0;
      while (vertex_q.size() > 0) begin
         int w;
         w = $urandom_range(0, 19);
         if (vertex_q.size() % 60 < 15) w = 0;
         if (w > 0) begin
            req_tvalid <= 0;
            repeat (w) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata <= vertex_q.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
